[rtl/core/dq_current_pi_vector_limit_macros.svh]
// Assertion macros for the dq current PI controller checker
`ifndef DQ_CURRENT_PI_VECTOR_LIMIT_MACROS_SVH
`define DQ_CURRENT_PI_VECTOR_LIMIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DQPI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dqpi: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DQPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dqpi: next-cycle check failed");

`endif

[rtl/core/dqpi_pkg.sv]
// Types, codes and saturation helpers for the dq current PI controller
package dqpi_pkg;

  localparam logic [1:0] CMD_STEP    = 2'd0;
  localparam logic [1:0] CMD_PRELOAD = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [2:0] REG_KP  = 3'd0;
  localparam logic [2:0] REG_KI  = 3'd1;
  localparam logic [2:0] REG_KAW = 3'd2;
  localparam logic [2:0] REG_LIM = 3'd3;
  localparam logic [2:0] REG_TS  = 3'd4;

  localparam logic [31:0] KP_RST  = 32'd0;
  localparam logic [31:0] KI_RST  = 32'd0;
  localparam logic [31:0] KAW_RST = 32'd0;
  localparam logic [30:0] LIM_RST = 31'd786432;
  localparam logic [31:0] TS_RST  = 32'd42950;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] ref_d;
    logic signed [31:0] ref_q;
    logic signed [31:0] fb_d;
    logic signed [31:0] fb_q;
    logic signed [31:0] req_d;
    logic signed [31:0] req_q;
  } in_t;

  typedef struct packed {
    logic signed [31:0] volt_d;
    logic signed [31:0] volt_q;
    logic signed [31:0] err_d;
    logic signed [31:0] err_q;
    logic signed [31:0] prop_d;
    logic signed [31:0] prop_q;
    logic signed [31:0] unsat_d;
    logic signed [31:0] unsat_q;
    logic signed [31:0] integ_d_out;
    logic signed [31:0] integ_q_out;
    logic               saturated;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_PROP, S_PROPW, S_UNS, S_SQ, S_SQW, S_ROOT, S_CMP,
    S_SCL, S_SCLW, S_DIV, S_DIVW, S_KI, S_KIW, S_KAW, S_KAWW, S_TS, S_TSW,
    S_PRE, S_OUT
  } state_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -68'sh0_0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // clamp to +-lim
  function automatic logic signed [31:0] clamp_lim(input logic signed [67:0] v,
                                                   input logic [30:0] lim);
    logic signed [67:0] l;
    logic signed [31:0] r;
    l = 68'(signed'({1'b0, lim}));
    if (v > l) r = 32'(signed'({1'b0, lim}));
    else if (v < -l) r = -32'(signed'({1'b0, lim}));
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/dqpi_mul.sv]
// Shared signed 33x33 multiplier with registered product
module dqpi_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);
  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

[rtl/core/dq_current_pi_vector_limit.sv]
// Top level of the dq current PI controller with vector limit and anti-windup
//
//  channel | ports                              | direction
//  in      | in_valid, in_ready, in_data        | item in
//  out     | out_valid, out_ready, out_data     | result item out
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | register write
//          | cfg_data                           |
//
// A step item runs error, proportional products, square root of the vector magnitude,
// limit compare and integrator update, each product through the shared multiplier; when
// the vector limit engages, each axis also takes a scale product and a divide.
// Preload computes the proportional terms first; clear and unused commands go straight to the result.
// Synchronous active-low reset clears control state, gains and integrators.
// in_ready is low from acceptance until the cycle after the result item is taken.
module dq_current_pi_vector_limit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dqpi_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dqpi_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dqpi_pkg::*;

  state_t state_r, state_nxt;

  logic [31:0] kp_r, ki_r, kaw_r, ts_r;
  logic [30:0] lim_r;

  in_t                in_r;
  logic               ax_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] err_r   [2];
  logic signed [31:0] prop_r  [2];
  logic signed [31:0] uns_r   [2];
  logic signed [31:0] volt_r  [2];
  logic signed [31:0] integ_r [2];
  logic               sat_r;
  logic signed [31:0] t1_r, corr_r;
  logic [63:0]        x_r;
  logic [34:0]        rem_r;
  logic [31:0]        root_r;
  logic [31:0]        drem_r, dq_r;
  logic               neg_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_r;
  logic signed [31:0] diff;
  logic signed [31:0] p_sh16;
  logic [34:0]        sq_rem, sq_trial;
  logic [32:0]        dv_t;
  logic [62:0]        abs_p;
  logic [32:0]        q_up;

  dqpi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) begin
                 if (in_data.cmd == CMD_STEP || in_data.cmd == CMD_PRELOAD) state_nxt = S_ERR;
                 else state_nxt = S_OUT;
               end
      S_ERR:   state_nxt = S_PROP;
      S_PROP:  state_nxt = S_PROPW;
      S_PROPW: if (!ax_r) state_nxt = S_PROP;
               else if (in_r.cmd == CMD_STEP) state_nxt = S_UNS;
               else state_nxt = S_PRE;
      S_UNS:   state_nxt = S_SQ;
      S_SQ:    state_nxt = S_SQW;
      S_SQW:   state_nxt = ax_r ? S_ROOT : S_SQ;
      S_ROOT:  if (cnt_r == '0) state_nxt = S_CMP;
      S_CMP:   state_nxt = ({1'b0, lim_r} < root_r) ? S_SCL : S_KI;
      S_SCL:   state_nxt = S_SCLW;
      S_SCLW:  state_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_DIVW;
      S_DIVW:  state_nxt = ax_r ? S_KI : S_SCL;
      S_KI:    state_nxt = S_KIW;
      S_KIW:   state_nxt = S_KAW;
      S_KAW:   state_nxt = S_KAWW;
      S_KAWW:  state_nxt = S_TS;
      S_TS:    state_nxt = S_TSW;
      S_TSW:   state_nxt = ax_r ? S_OUT : S_KI;
      S_PRE:   state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and multiplier operand select
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    cfg_ready = 1'b1;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_PROP: begin mul_a = {1'b0, kp_r};  mul_b = 33'(err_r[ax_r]); end
      S_SQ:   begin mul_a = 33'(uns_r[ax_r]); mul_b = 33'(uns_r[ax_r]); end
      S_SCL:  begin mul_a = 33'(uns_r[ax_r]); mul_b = {2'b0, lim_r}; end
      S_KI:   begin mul_a = {1'b0, ki_r};  mul_b = 33'(err_r[ax_r]); end
      S_KAW:  begin mul_a = {1'b0, kaw_r}; mul_b = 33'(diff); end
      S_TS:   begin mul_a = 33'(corr_r);   mul_b = {1'b0, ts_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // datapath helpers
  always_comb begin
    diff     = sat32(68'(volt_r[ax_r]) - 68'(uns_r[ax_r]));
    p_sh16   = sat32(68'(p_r >>> 16));
    sq_rem   = {rem_r[32:0], x_r[63:62]};
    sq_trial = {1'b0, root_r, 2'b01};
    dv_t     = {drem_r, dq_r[31]};
    abs_p    = p_r[65] ? 63'(-p_r) : p_r[62:0];
    q_up     = {1'b0, dq_r} + {32'd0, (drem_r != '0)};
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= 1'b0;
      cnt_r   <= '0;
      kp_r    <= KP_RST;
      ki_r    <= KI_RST;
      kaw_r   <= KAW_RST;
      lim_r   <= LIM_RST;
      ts_r    <= TS_RST;
      integ_r[0] <= '0;
      integ_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_KP:  kp_r  <= cfg_data;
          REG_KI:  ki_r  <= cfg_data;
          REG_KAW: kaw_r <= cfg_data;
          REG_LIM: lim_r <= cfg_data[30:0];
          REG_TS:  ts_r  <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE:  begin
                   ax_r <= 1'b0;
                   if (in_valid && in_data.cmd == CMD_CLEAR) begin
                     integ_r[0] <= '0;
                     integ_r[1] <= '0;
                   end
                 end
        S_PROPW, S_DIVW: ax_r <= ~ax_r;
        S_SQW:   begin
                   ax_r  <= ~ax_r;
                   cnt_r <= 5'd31;
                 end
        S_SCLW:  cnt_r <= 5'd31;
        S_ROOT, S_DIV: cnt_r <= cnt_r - 5'd1;
        S_CMP:   ax_r <= 1'b0;
        S_TSW:   begin
                   ax_r <= ~ax_r;
                   integ_r[ax_r] <= clamp_lim(68'(integ_r[ax_r]) + 68'(p_r >>> 32), lim_r);
                 end
        S_PRE:   begin
                   integ_r[0] <= clamp_lim(68'(in_r.req_d) - 68'(prop_r[0]), lim_r);
                   integ_r[1] <= clamp_lim(68'(in_r.req_q) - 68'(prop_r[1]), lim_r);
                 end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE:  if (in_valid) begin
                 in_r <= in_data;
                 for (int i = 0; i < 2; i++) begin
                   err_r[i]  <= '0;
                   prop_r[i] <= '0;
                   uns_r[i]  <= '0;
                   volt_r[i] <= '0;
                 end
                 sat_r <= 1'b0;
               end
      S_ERR:   begin
                 err_r[0] <= sat32(68'(in_r.ref_d) - 68'(in_r.fb_d));
                 err_r[1] <= sat32(68'(in_r.ref_q) - 68'(in_r.fb_q));
               end
      S_PROPW: prop_r[ax_r] <= p_sh16;
      S_UNS:   begin
                 uns_r[0] <= sat32(68'(prop_r[0]) + 68'(integ_r[0]));
                 uns_r[1] <= sat32(68'(prop_r[1]) + 68'(integ_r[1]));
               end
      S_SQW:   begin
                 x_r    <= ax_r ? x_r + p_r[63:0] : p_r[63:0];
                 rem_r  <= '0;
                 root_r <= '0;
               end
      // one result bit of the square root per cycle
      S_ROOT:  begin
                 x_r <= {x_r[61:0], 2'b00};
                 if (sq_rem >= sq_trial) begin
                   rem_r  <= sq_rem - sq_trial;
                   root_r <= {root_r[30:0], 1'b1};
                 end else begin
                   rem_r  <= sq_rem;
                   root_r <= {root_r[30:0], 1'b0};
                 end
               end
      S_CMP:   begin
                 sat_r <= ({1'b0, lim_r} < root_r);
                 if (!({1'b0, lim_r} < root_r)) begin
                   volt_r[0] <= uns_r[0];
                   volt_r[1] <= uns_r[1];
                 end
               end
      S_SCLW:  begin
                 neg_r  <= p_r[65];
                 drem_r <= {1'b0, abs_p[62:32]};
                 dq_r   <= abs_p[31:0];
               end
      // one quotient bit per cycle
      S_DIV:   begin
                 if (dv_t >= {1'b0, root_r}) begin
                   drem_r <= 32'(dv_t - {1'b0, root_r});
                   dq_r   <= {dq_r[30:0], 1'b1};
                 end else begin
                   drem_r <= dv_t[31:0];
                   dq_r   <= {dq_r[30:0], 1'b0};
                 end
               end
      S_DIVW:  volt_r[ax_r] <= neg_r ? 32'(-q_up) : dq_r;
      S_KIW:   t1_r <= p_sh16;
      S_KAWW:  corr_r <= sat32(68'(t1_r) + 68'(p_sh16));
      default: ;
    endcase
  end

  // result item
  always_comb begin
    out_data.volt_d      = volt_r[0];
    out_data.volt_q      = volt_r[1];
    out_data.err_d       = err_r[0];
    out_data.err_q       = err_r[1];
    out_data.prop_d      = prop_r[0];
    out_data.prop_q      = prop_r[1];
    out_data.unsat_d     = uns_r[0];
    out_data.unsat_q     = uns_r[1];
    out_data.integ_d_out = integ_r[0];
    out_data.integ_q_out = integ_r[1];
    out_data.saturated   = sat_r;
  end

endmodule

[rtl/core/dqpi_checker.sv]
// Port-level checker for the dq current PI controller, with its bind
`include "dq_current_pi_vector_limit_macros.svh"

module dqpi_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input dqpi_pkg::out_t out_data
);
  // a stalled result item holds its payload
  `DQPI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // one item at a time: busy after acceptance
  `DQPI_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  // no new item while a result waits
  `DQPI_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)
endmodule

bind dq_current_pi_vector_limit dqpi_checker u_dqpi_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[dv/tb_dq_current_pi_vector_limit.sv]
// Self-checking testbench for the dq current PI controller with vector limit

// Predicts result items from accepted items and checks what the block returns
class pi_volt_scoreboard;
  bit [31:0] kp, ki, kaw, ts;
  bit [30:0] lim;
  longint integ_d, integ_q;
  dqpi_pkg::out_t pending_results[$];
  int mismatches, checked, n_step, n_sat, n_pre, n_clr, n_other;

  function new();
    kp = dqpi_pkg::KP_RST;  ki = dqpi_pkg::KI_RST;  kaw = dqpi_pkg::KAW_RST;
    lim = dqpi_pkg::LIM_RST; ts = dqpi_pkg::TS_RST;
    integ_d = 0; integ_q = 0;
  endfunction

  // register write as the block takes it; unknown indexes do nothing
  function void write_reg(bit [2:0] idx, bit [31:0] data);
    case (idx)
      dqpi_pkg::REG_KP:  kp = data;
      dqpi_pkg::REG_KI:  ki = data;
      dqpi_pkg::REG_KAW: kaw = data;
      dqpi_pkg::REG_LIM: lim = data[30:0];
      dqpi_pkg::REG_TS:  ts = data;
      default: ;
    endcase
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint clip_lim(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function longint div_floor(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function bit [63:0] root64(bit [63:0] x);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // work out the result of one accepted item and queue it
  function void note_item(dqpi_pkg::in_t it);
    longint e[2], p[2], u[2], v[2], ig[2], r[2], f[2], q[2];
    longint l, diff, corr, delta;
    bit [63:0] sumsq, mag;
    bit sat;
    dqpi_pkg::out_t o;
    l = longint'(lim);
    ig[0] = integ_d; ig[1] = integ_q;
    r[0] = longint'(it.ref_d); r[1] = longint'(it.ref_q);
    f[0] = longint'(it.fb_d);  f[1] = longint'(it.fb_q);
    q[0] = longint'(it.req_d); q[1] = longint'(it.req_q);
    e = '{0, 0}; p = '{0, 0}; u = '{0, 0}; v = '{0, 0};
    sat = 0;
    if (it.cmd == dqpi_pkg::CMD_STEP || it.cmd == dqpi_pkg::CMD_PRELOAD) begin
      for (int i = 0; i < 2; i++) begin
        e[i] = clip32(r[i] - f[i]);
        p[i] = clip32((longint'(kp) * e[i]) >>> 16);
      end
    end
    if (it.cmd == dqpi_pkg::CMD_STEP) begin
      n_step++;
      for (int i = 0; i < 2; i++) u[i] = clip32(p[i] + ig[i]);
      sumsq = 64'(u[0] * u[0]) + 64'(u[1] * u[1]);
      mag = root64(sumsq);
      sat = mag > 64'(l);
      n_sat += sat;
      for (int i = 0; i < 2; i++) begin
        v[i] = sat ? div_floor(u[i] * l, longint'(mag)) : u[i];
        diff = clip32(v[i] - u[i]);
        corr = clip32(clip32((longint'(ki) * e[i]) >>> 16) +
                      clip32((longint'(kaw) * diff) >>> 16));
        delta = (corr * longint'(ts)) >>> 32;
        ig[i] = clip_lim(ig[i] + delta, l);
      end
    end else if (it.cmd == dqpi_pkg::CMD_PRELOAD) begin
      n_pre++;
      for (int i = 0; i < 2; i++) ig[i] = clip_lim(q[i] - p[i], l);
    end else if (it.cmd == dqpi_pkg::CMD_CLEAR) begin
      n_clr++;
      ig = '{0, 0};
    end else begin
      n_other++;
    end
    integ_d = ig[0]; integ_q = ig[1];
    o.volt_d = v[0][31:0];  o.volt_q = v[1][31:0];
    o.err_d = e[0][31:0];   o.err_q = e[1][31:0];
    o.prop_d = p[0][31:0];  o.prop_q = p[1][31:0];
    o.unsat_d = u[0][31:0]; o.unsat_q = u[1][31:0];
    o.integ_d_out = ig[0][31:0]; o.integ_q_out = ig[1][31:0];
    o.saturated = sat;
    pending_results.push_back(o);
  endfunction

  // compare one result item with the oldest prediction
  function void check_result(dqpi_pkg::out_t got);
    dqpi_pkg::out_t want;
    logic [31:0] w[11], g[11];
    string names[11];
    bit bad;
    names = '{"volt_d", "volt_q", "err_d", "err_q", "prop_d", "prop_q",
              "unsat_d", "unsat_q", "integ_d_out", "integ_q_out", "saturated"};
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result item with none outstanding");
      return;
    end
    want = pending_results.pop_front();
    checked++;
    w = '{want.volt_d, want.volt_q, want.err_d, want.err_q, want.prop_d, want.prop_q,
          want.unsat_d, want.unsat_q, want.integ_d_out, want.integ_q_out,
          32'(want.saturated)};
    g = '{got.volt_d, got.volt_q, got.err_d, got.err_q, got.prop_d, got.prop_q,
          got.unsat_d, got.unsat_q, got.integ_d_out, got.integ_q_out,
          32'(got.saturated)};
    bad = 0;
    for (int i = 0; i < 11; i++) begin
      if (g[i] !== w[i]) begin
        if (!bad) mismatches++;
        bad = 1;
        if (mismatches <= 10)
          $display("ERROR: result %0d field %s expected %h got %h",
                   checked, names[i], w[i], g[i]);
      end
    end
  endfunction
endclass

module tb_dq_current_pi_vector_limit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  dqpi_pkg::in_t  in_data;
  dqpi_pkg::out_t out_data;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pi_volt_scoreboard sb = new();
  int burst_left = 0;
  bit no_gaps = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int rx_cycle = 0;

  dq_current_pi_vector_limit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_item(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: stall pattern that changes mode, plus one long hold-off on request
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 60 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) >= 3);
        default: out_ready <= ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic dqpi_pkg::in_t rand_item();
    dqpi_pkg::in_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) it.cmd = dqpi_pkg::CMD_STEP;
    else if (r < 84) it.cmd = dqpi_pkg::CMD_PRELOAD;
    else if (r < 93) it.cmd = dqpi_pkg::CMD_CLEAR;
    else it.cmd = 2'(dqpi_pkg::CMD_CLEAR + 1);
    it.ref_d = pick_value(); it.ref_q = pick_value();
    it.fb_d = pick_value();  it.fb_q = pick_value();
    it.req_d = pick_value(); it.req_q = pick_value();
    return it;
  endfunction

  function automatic dqpi_pkg::in_t mk_item(logic [1:0] c, logic [31:0] rd, logic [31:0] rq,
                                            logic [31:0] fd, logic [31:0] fq,
                                            logic [31:0] qd, logic [31:0] qq);
    dqpi_pkg::in_t it;
    it.cmd = c; it.ref_d = rd; it.ref_q = rq; it.fb_d = fd; it.fb_q = fq;
    it.req_d = qd; it.req_q = qq;
    return it;
  endfunction

  // offer one item; valid stays high until taken, gaps come between bursts unless no_gaps is set
  task automatic send_item(dqpi_pkg::in_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 12);
      if (!no_gaps) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (k == n / 2) hold_req = 1;
      send_item(rand_item());
    end
  endtask

  // wait until every predicted result item has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kaw,
                           logic [31:0] lim, logic [31:0] ts);
    write_reg(dqpi_pkg::REG_KP, kp);
    write_reg(dqpi_pkg::REG_KI, ki);
    write_reg(dqpi_pkg::REG_KAW, kaw);
    write_reg(dqpi_pkg::REG_LIM, lim);
    write_reg(dqpi_pkg::REG_TS, ts);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_data = '0;
    out_ready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed, reset settings: every command incl. the unused one
    send_item(mk_item(dqpi_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(dqpi_pkg::CMD_PRELOAD, 0, 0, 0, 0, 32'h0010_0000, 32'hFFF0_0000));
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0));
    send_item(mk_item(2'(dqpi_pkg::CMD_CLEAR + 1), 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(dqpi_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    drain();

    // moderate gains, integrators move and the vector limit engages
    write_all(32'h0001_8000, 32'h0050_0000, 32'h0010_0000, 32'h000C_0000, 32'h0010_0000);
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h0014_0000, 32'h0014_0000, 0, 0, 0, 0));
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h0014_0000, 32'h0014_0000, 0, 0, 0, 0));
    send_item(mk_item(dqpi_pkg::CMD_PRELOAD, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    send_random(150);
    drain();

    // all registers at their top values
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    send_item(mk_item(dqpi_pkg::CMD_PRELOAD, 1, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(mk_item(dqpi_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
    send_random(70);
    drain();

    // zero limit (top data bit is dropped) and zero sample period
    write_all(32'h0000_8000, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 32'h0);
    send_item(mk_item(dqpi_pkg::CMD_STEP, 32'h0001_0000, 32'h0003_0000, 0, 0, 0, 0));
    send_item(mk_item(dqpi_pkg::CMD_PRELOAD, 0, 0, 0, 0, 32'h0005_0000, 32'h0005_0000));
    send_random(50);
    drain();

    // writes past the register list, then random settings with a limit of 1
    write_reg(3'(dqpi_pkg::REG_TS + 1), 32'hDEAD_BEEF);
    write_reg(3'(dqpi_pkg::REG_TS + 2), 32'h1234_5678);
    write_reg(3'(dqpi_pkg::REG_TS + 3), 32'hFFFF_FFFF);
    write_all($urandom_range(0, 32'h0004_0000), $urandom, $urandom_range(0, 32'h0100_0000),
              1, $urandom);
    send_random(40);
    drain();
    write_all($urandom_range(0, 32'h0004_0000), $urandom, $urandom,
              $urandom_range(32'h0001_0000, 32'h0040_0000), $urandom);
    send_random(80);
    drain();

    $display("Covered %0d step (%0d limited), %0d preload, %0d clear, %0d unused items",
             sb.n_step, sb.n_sat, sb.n_pre, sb.n_clr, sb.n_other);
    $display("%0d result items checked, %0d mismatching", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
